// File: design/fdtd_pkg.sv
// Shared types, constants and field widths of the FDTD electric-field update.
// Used by every module of the block; no dependencies.
package fdtd_pkg;

  localparam int FRAC_BITS_DEFAULT = 16;
  localparam int DATA_W            = 32;
  localparam int EPS_W             = 31;
  localparam int NUM_W             = 67;   // signed numerator: three products summed
  localparam int MAG_W             = 66;   // numerator magnitude
  localparam int QCLAMP_W          = 41;   // quotient magnitude clamp at 2^40
  localparam int IN_TDATA_W        = 224;
  localparam int OUT_TDATA_W       = 40;
  localparam int CFG_IDX_W         = 2;

  localparam logic [1:0] ACT_EX  = 2'd0;
  localparam logic [1:0] ACT_EY  = 2'd1;
  localparam logic [1:0] ACT_EZ  = 2'd2;
  localparam logic [1:0] ACT_NOP = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  localparam logic [1:0] REG_DT = 2'd0;
  localparam logic [1:0] REG_DX = 2'd1;
  localparam logic [1:0] REG_DY = 2'd2;
  localparam logic [1:0] REG_DZ = 2'd3;

  // Item side info that rides along the divider.
  typedef struct packed {
    logic [DATA_W-1:0] field_old;
    logic              neg;
    logic              zero_eps;
    logic              skip;
  } side_t;

endpackage

// File: design/fdtd_front.sv
// Front stages: coefficient selection, differences, three products, signed sum and magnitude.
// Uses fdtd_pkg. Three register stages, advancing under a common enable.
module fdtd_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [1:0]                          action,
  input  logic signed [fdtd_pkg::DATA_W-1:0]  field_old,
  input  logic signed [fdtd_pkg::DATA_W-1:0]  current_density,
  input  logic [fdtd_pkg::EPS_W-1:0]          permittivity,
  input  logic signed [fdtd_pkg::DATA_W-1:0]  first_next,
  input  logic signed [fdtd_pkg::DATA_W-1:0]  first_here,
  input  logic signed [fdtd_pkg::DATA_W-1:0]  second_next,
  input  logic signed [fdtd_pkg::DATA_W-1:0]  second_here,
  input  logic signed [fdtd_pkg::DATA_W-1:0]  time_step,
  input  logic signed [fdtd_pkg::DATA_W-1:0]  step_over_dx,
  input  logic signed [fdtd_pkg::DATA_W-1:0]  step_over_dy,
  input  logic signed [fdtd_pkg::DATA_W-1:0]  step_over_dz,
  output logic                                out_valid,
  output logic [fdtd_pkg::MAG_W-1:0]          mag,
  output logic [fdtd_pkg::EPS_W-1:0]          eps,
  output fdtd_pkg::side_t                     side
);

  localparam int W = fdtd_pkg::DATA_W;

  logic                v1, v2, v3;
  logic signed [W:0]   d1, d2;
  logic signed [W-1:0] c1, c2, dt, j1;
  logic [fdtd_pkg::EPS_W-1:0] eps1, eps2;
  fdtd_pkg::side_t     s1, s2;
  logic signed [2*W:0] p_j, p_1, p_2;
  logic signed [fdtd_pkg::NUM_W-1:0] num;
  logic signed [W-1:0] c1_next, c2_next;

  always_comb begin
    case (action)
      fdtd_pkg::ACT_EX: begin c1_next = step_over_dy; c2_next = step_over_dz; end
      fdtd_pkg::ACT_EY: begin c1_next = step_over_dz; c2_next = step_over_dx; end
      default:          begin c1_next = step_over_dx; c2_next = step_over_dy; end
    endcase
  end

  assign num = {{(fdtd_pkg::NUM_W-2*W-1){p_1[2*W]}}, p_1}
             - {{(fdtd_pkg::NUM_W-2*W-1){p_j[2*W]}}, p_j}
             - {{(fdtd_pkg::NUM_W-2*W-1){p_2[2*W]}}, p_2};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
    if (en) begin
      d1   <= {first_next[W-1], first_next} - {first_here[W-1], first_here};
      d2   <= {second_next[W-1], second_next} - {second_here[W-1], second_here};
      c1   <= c1_next;
      c2   <= c2_next;
      dt   <= time_step;
      j1   <= current_density;
      eps1 <= permittivity;
      s1.field_old <= field_old;
      s1.neg       <= 1'b0;
      s1.zero_eps  <= (permittivity == '0);
      s1.skip      <= (action == fdtd_pkg::ACT_NOP) || (permittivity == '0);

      p_j  <= dt * j1;
      p_1  <= c1 * d1;
      p_2  <= c2 * d2;
      eps2 <= eps1;
      s2   <= s1;

      mag  <= num[fdtd_pkg::NUM_W-1] ? fdtd_pkg::MAG_W'(-num) : fdtd_pkg::MAG_W'(num);
      eps  <= eps2;
      side <= '{field_old: s2.field_old, neg: num[fdtd_pkg::NUM_W-1],
                zero_eps: s2.zero_eps, skip: s2.skip};
    end
  end

  assign out_valid = v3;

endmodule

// File: design/fdtd_div.sv
// Pipelined restoring divider: one quotient bit per stage, quotient clamped at 2^40.
// Uses fdtd_pkg. MAG_W stages advancing under a common enable.
module fdtd_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [fdtd_pkg::MAG_W-1:0]  mag,
  input  logic [fdtd_pkg::EPS_W-1:0]  eps,
  input  fdtd_pkg::side_t             side_in,
  output logic                        out_valid,
  output logic [fdtd_pkg::QCLAMP_W-1:0] quot,
  output fdtd_pkg::side_t             side_out
);

  localparam int N  = fdtd_pkg::MAG_W;
  localparam int RW = fdtd_pkg::EPS_W + 1;

  logic [N-1:0]             v;
  logic [N-1:0]             q [N];
  logic [RW-1:0]            r [N];
  logic [fdtd_pkg::EPS_W-1:0] d [N];
  fdtd_pkg::side_t          s [N];

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_stage
      logic [N-1:0]  q_in;
      logic [RW-1:0] r_in, trial;
      logic [fdtd_pkg::EPS_W-1:0] d_in;
      if (k == 0) begin : g_first
        assign q_in = mag;
        assign r_in = '0;
        assign d_in = eps;
      end else begin : g_rest
        assign q_in = q[k-1];
        assign r_in = r[k-1];
        assign d_in = d[k-1];
      end
      assign trial = {r_in[RW-2:0], q_in[N-1]};
      always_ff @(posedge clk) begin
        if (rst) begin
          v[k] <= 1'b0;
        end else if (en) begin
          v[k] <= (k == 0) ? in_valid : v[k-1 < 0 ? 0 : k-1];
        end
        if (en) begin
          if (trial >= {1'b0, d_in}) begin
            r[k] <= trial - {1'b0, d_in};
            q[k] <= {q_in[N-2:0], 1'b1};
          end else begin
            r[k] <= trial;
            q[k] <= {q_in[N-2:0], 1'b0};
          end
          d[k] <= d_in;
          s[k] <= (k == 0) ? side_in : s[k-1 < 0 ? 0 : k-1];
        end
      end
    end
  endgenerate

  assign out_valid = v[N-1];
  assign side_out  = s[N-1];
  assign quot = (|q[N-1][N-1:fdtd_pkg::QCLAMP_W-1]) ?
                fdtd_pkg::QCLAMP_W'(1) << (fdtd_pkg::QCLAMP_W-1) :
                q[N-1][fdtd_pkg::QCLAMP_W-1:0];

endmodule

// File: design/fdtd_back.sv
// Final stage: signed add of the increment, saturation and status.
// Uses fdtd_pkg. One result register; the two-entry skid toward the receiver is in the top level.
module fdtd_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [fdtd_pkg::QCLAMP_W-1:0] quot,
  input  fdtd_pkg::side_t               side,
  output logic                          res_valid,
  output logic [fdtd_pkg::DATA_W-1:0]   res_field,
  output logic [1:0]                    res_status
);

  localparam int W  = fdtd_pkg::DATA_W;
  localparam int SW = fdtd_pkg::QCLAMP_W + 2;

  logic signed [SW-1:0] sum;
  logic [W-1:0]  field_next;
  logic [1:0]    status_next;

  assign sum = SW'(signed'(side.field_old))
             + (side.neg ? -SW'(quot) : SW'(quot));

  always_comb begin
    field_next  = side.field_old;
    status_next = side.zero_eps ? fdtd_pkg::ST_ZERO : fdtd_pkg::ST_OK;
    if (!side.skip) begin
      if (sum > SW'(32'sh7FFF_FFFF)) begin
        field_next  = 32'h7FFF_FFFF;
        status_next = fdtd_pkg::ST_SAT;
      end else if (sum < -SW'(33'sh0_8000_0000)) begin
        field_next  = 32'h8000_0000;
        status_next = fdtd_pkg::ST_SAT;
      end else begin
        field_next  = sum[W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= in_valid;
    end
    if (en) begin
      res_field  <= field_next;
      res_status <= status_next;
    end
  end

endmodule

// File: design/fdtd_electric_field_update_eps.sv
// FDTD electric-field update with per-cell permittivity, top level.
// Uses fdtd_pkg, fdtd_front, fdtd_div and fdtd_back.
//
// Channels: s_axis carries one cell per transfer (action in tuser, the other
// fields in tdata); m_axis returns field_new and status per transfer. The
// configuration port writes dt and dt/dx, dt/dy, dt/dz by index, no wait.
// Throughput: one cell per cycle while the pipeline advances. Pipeline: 3
// front stages, 66 divider stages (one quotient bit each), 1 result stage and
// the skid. The pipeline advances whenever its last stage is empty or the
// output skid has room; a two-entry skid keeps s_axis_tready independent of
// m_axis_tready in the same cycle, so a receiver stall stops the pipeline once
// its last stage holds an item, and loses and repeats nothing. Reset clears
// all valid bits, empties the skid and sets the four configuration registers
// to zero.
module fdtd_electric_field_update_eps (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // field_old, current_density, permittivity, first_next, first_here,
  // second_next, second_here (low to high), zero fill
  input  logic [fdtd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic [1:0]                          s_axis_tuser,   // action
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // field_new, status (low to high), zero fill
  output logic [fdtd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                                cfg_we,
  input  logic [fdtd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fdtd_pkg::DATA_W-1:0]         cfg_data
);

  localparam int W = fdtd_pkg::DATA_W;

  logic signed [W-1:0] time_step, step_over_dx, step_over_dy, step_over_dz;
  logic en, fv, dv, bv;
  logic [fdtd_pkg::MAG_W-1:0] mag;
  logic [fdtd_pkg::EPS_W-1:0] eps;
  fdtd_pkg::side_t fs, ds;
  logic [fdtd_pkg::QCLAMP_W-1:0] quot;
  logic [W-1:0] bfield;
  logic [1:0] bstatus;

  logic [W+1:0] sk0, sk1;
  logic [1:0]   cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step    <= '0;
      step_over_dx <= '0;
      step_over_dy <= '0;
      step_over_dz <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        fdtd_pkg::REG_DT: time_step    <= cfg_data;
        fdtd_pkg::REG_DX: step_over_dx <= cfg_data;
        fdtd_pkg::REG_DY: step_over_dy <= cfg_data;
        fdtd_pkg::REG_DZ: step_over_dz <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance while the skid can take whatever leaves the last stage.
  assign en = (cnt != 2'd2) || !bv;
  assign s_axis_tready = en;

  fdtd_front u_front (
    .clk, .rst, .en,
    .in_valid(s_axis_tvalid),
    .action(s_axis_tuser),
    .field_old(s_axis_tdata[31:0]),
    .current_density(s_axis_tdata[63:32]),
    .permittivity(s_axis_tdata[94:64]),
    .first_next(s_axis_tdata[126:95]),
    .first_here(s_axis_tdata[158:127]),
    .second_next(s_axis_tdata[190:159]),
    .second_here(s_axis_tdata[222:191]),
    .time_step, .step_over_dx, .step_over_dy, .step_over_dz,
    .out_valid(fv), .mag, .eps, .side(fs)
  );

  fdtd_div u_div (
    .clk, .rst, .en, .in_valid(fv), .mag, .eps, .side_in(fs),
    .out_valid(dv), .quot, .side_out(ds)
  );

  fdtd_back u_back (
    .clk, .rst, .en, .in_valid(dv), .quot, .side(ds),
    .res_valid(bv), .res_field(bfield), .res_status(bstatus)
  );

  logic push, pop, to_head;
  assign push    = en && bv;
  assign pop     = m_axis_tvalid && m_axis_tready;
  assign to_head = (cnt == 2'd0) || (cnt == 2'd1 && pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
    if (push && to_head) begin
      sk0 <= {bstatus, bfield};
    end else if (pop) begin
      sk0 <= sk1;
    end
    if (push && !to_head) begin
      sk1 <= {bstatus, bfield};
    end
  end

  assign m_axis_tvalid = (cnt != 2'd0);
  assign m_axis_tdata  = {6'd0, sk0};

endmodule

// File: design/fdtd_checker.sv
// Port-level checker for the FDTD electric-field update, bound to the top level.
// Uses fdtd_pkg for status codes.
module fdtd_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [fdtd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[33:32] <= fdtd_pkg::ST_ZERO))
    else $error("status code out of range");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[39:34] == 6'd0))
    else $error("tdata fill not zero");

  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[33:32] == fdtd_pkg::ST_SAT) |->
    (m_axis_tdata[31:0] == 32'h7FFF_FFFF || m_axis_tdata[31:0] == 32'h8000_0000))
    else $error("saturated result not at a bound");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

bind fdtd_electric_field_update_eps fdtd_checker u_checker (
  .clk, .rst, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
